[src/pidis_pkg.sv]
// Shared types, constants and saturation helpers for the PID integral-separation core.
`default_nettype none

package pidis_pkg;

  localparam int CHANNELS_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CHAN_W          = 2;
  localparam int THR_W           = 31;
  localparam int ADJ_W           = 15;

  typedef enum logic {
    KIND_CONFIG = 1'b0,
    KIND_STEP   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_KP_RED    = 2'd1,
    REG_KD_ADJ    = 2'd2
  } reg_idx_e;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    kind_e              kind;
    logic [CHAN_W-1:0]  ch;
    logic signed [31:0] err;
    logic               band;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
  } qitem_t;

  typedef struct packed {
    logic [ADJ_W-1:0] kp_red;
    logic [ADJ_W-1:0] kd_adj;
  } gain_adj_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/pidis_front.sv]
// Front end: accepts requests, computes the saturated error and classifies it against the band.
`default_nettype none

module pidis_front
  import pidis_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     kind_i,
  input  wire logic [CHAN_W-1:0]        channel_i,
  input  wire logic signed [31:0]       target_i,
  input  wire logic signed [31:0]       measured_i,
  input  wire logic signed [15:0]       gain_p_i,
  input  wire logic signed [15:0]       gain_i_i,
  input  wire logic signed [15:0]       gain_d_i,
  input  wire logic [THR_W-1:0]         threshold_i,
  input  wire logic                     q_full_i,
  output logic                          q_push_o,
  output qitem_t                        q_item_o
);

  logic signed [32:0] diff;
  logic signed [31:0] err;
  logic [31:0]        mag;
  logic               ch_ok;

  assign in_ready_o = !q_full_i;

  assign diff = {target_i[31], target_i} - {measured_i[31], measured_i};
  assign err  = sat32(diff);
  // The most negative error negates to 2^31, which no threshold can exceed.
  assign mag  = err[31] ? (32'd0 - err) : err;

  assign ch_ok = (32'(channel_i) < 32'(CHANNELS));

  // Requests for a channel that does not exist are taken and dropped.
  assign q_push_o = in_valid_i && in_ready_o && ch_ok;

  always_comb begin
    q_item_o.kind   = kind_e'(kind_i);
    q_item_o.ch     = channel_i;
    q_item_o.err    = err;
    q_item_o.band   = (mag < {1'b0, threshold_i});
    q_item_o.gain_p = gain_p_i;
    q_item_o.gain_i = gain_i_i;
    q_item_o.gain_d = gain_d_i;
  end

endmodule

`default_nettype wire

[src/pidis_queue.sv]
// Small FIFO that decouples the front end from the back end.
`default_nettype none

module pidis_queue
  import pidis_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[src/pidis_back.sv]
// Back end: per-channel state, gain adjustment, the three products and the output register.
`default_nettype none

module pidis_back
  import pidis_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  output logic                    q_pop_o,
  input  wire qitem_t             q_item_i,
  input  wire gain_adj_t          adj_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [CHAN_W-1:0]       out_channel_o,
  output logic signed [31:0]      drive_o,
  output logic signed [31:0]      error_now_o,
  output logic signed [31:0]      integral_now_o,
  output logic                    separated_o
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Per-channel state
  logic signed [15:0] base_kp_q [CHANNELS];
  logic signed [15:0] base_ki_q [CHANNELS];
  logic signed [15:0] base_kd_q [CHANNELS];
  logic signed [31:0] prev_err_q [CHANNELS];
  logic signed [31:0] err_sum_q [CHANNELS];

  // Product stage
  logic                s1_valid_q;
  logic [CHAN_W-1:0]   s1_ch_q;
  logic signed [31:0]  s1_err_q;
  logic signed [31:0]  s1_sum_q;
  logic                s1_sep_q;
  logic signed [47:0]  s1_p_q, s1_p_d;
  logic signed [47:0]  s1_i_q, s1_i_d;
  logic signed [48:0]  s1_d_q, s1_d_d;

  // Output register
  logic                out_valid_q;
  logic [CHAN_W-1:0]   out_ch_q;
  logic signed [31:0]  drive_q, drive_d;
  logic signed [31:0]  out_err_q;
  logic signed [31:0]  out_sum_q;
  logic                out_sep_q;

  logic               out_free, s1_free, s1_adv, pop_step, pop_cfg;
  logic [IdxW-1:0]    idx;
  logic signed [15:0] bkp, bki, bkd;
  logic signed [15:0] kp, ki, kd;
  logic signed [31:0] sum_new;
  logic signed [32:0] dif;
  logic signed [50:0] total;
  logic signed [42:0] shr;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_free  = !s1_valid_q || out_free;
  assign s1_adv   = s1_valid_q && out_free;
  assign q_pop_o  = q_valid_i && s1_free;
  assign pop_step = q_pop_o && (q_item_i.kind == KIND_STEP);
  assign pop_cfg  = q_pop_o && (q_item_i.kind == KIND_CONFIG);

  assign idx = IdxW'(q_item_i.ch);
  assign bkp = base_kp_q[idx];
  assign bki = base_ki_q[idx];
  assign bkd = base_kd_q[idx];

  always_comb begin
    if (q_item_i.band) begin
      kp      = sat16({bkp[15], bkp} - {2'b00, adj_i.kp_red});
      kd      = sat16({bkd[15], bkd} - {2'b00, adj_i.kd_adj});
      ki      = bki;
      sum_new = sat32({err_sum_q[idx][31], err_sum_q[idx]}
                      + {q_item_i.err[31], q_item_i.err});
    end else begin
      kp      = bkp;
      kd      = sat16({bkd[15], bkd} + {2'b00, adj_i.kd_adj});
      ki      = '0;
      sum_new = '0;
    end
    // The derivative difference keeps its full 33 bits.
    dif    = {q_item_i.err[31], q_item_i.err} - {prev_err_q[idx][31], prev_err_q[idx]};
    s1_p_d = kp * q_item_i.err;
    s1_i_d = ki * sum_new;
    s1_d_d = kd * dif;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        base_kp_q[c]  <= '0;
        base_ki_q[c]  <= '0;
        base_kd_q[c]  <= '0;
        prev_err_q[c] <= '0;
        err_sum_q[c]  <= '0;
      end
    end else if (pop_cfg) begin
      base_kp_q[idx]  <= q_item_i.gain_p;
      base_ki_q[idx]  <= q_item_i.gain_i;
      base_kd_q[idx]  <= q_item_i.gain_d;
      prev_err_q[idx] <= '0;
      err_sum_q[idx]  <= '0;
    end else if (pop_step) begin
      prev_err_q[idx] <= q_item_i.err;
      err_sum_q[idx]  <= sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_step) begin
        s1_valid_q <= 1'b1;
      end else if (out_free) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_step) begin
      s1_ch_q  <= q_item_i.ch;
      s1_err_q <= q_item_i.err;
      s1_sum_q <= sum_new;
      s1_sep_q <= !q_item_i.band;
      s1_p_q   <= s1_p_d;
      s1_i_q   <= s1_i_d;
      s1_d_q   <= s1_d_d;
    end
  end

  // Exact sum of the Q24.24 products, then a floor shift back to Q16.16.
  assign total = {{3{s1_p_q[47]}}, s1_p_q} + {{3{s1_i_q[47]}}, s1_i_q}
               + {{2{s1_d_q[48]}}, s1_d_q};
  assign shr   = total[50:8];

  always_comb begin
    if ((&shr[42:31]) || !(|shr[42:31])) begin
      drive_d = shr[31:0];
    end else begin
      drive_d = shr[42] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_ch_q  <= s1_ch_q;
      drive_q   <= drive_d;
      out_err_q <= s1_err_q;
      out_sum_q <= s1_sum_q;
      out_sep_q <= s1_sep_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_channel_o  = out_ch_q;
  assign drive_o        = drive_q;
  assign error_now_o    = out_err_q;
  assign integral_now_o = out_sum_q;
  assign separated_o    = out_sep_q;

endmodule

`default_nettype wire

[src/pid_integral_separation_core.sv]
// Multi-channel positional PID with integral separation, top level.
// Path: an accepted step request passes the queue, the product stage register and the output
// register in turn; back-pressure from a full queue or a stalled output can hold it.
// Throughput: one request per cycle unless stalled; the channel state updates in that cycle.
// Reset: all channel gains, error history and sums clear to zero; registers take defaults.
`default_nettype none

module pid_integral_separation_core
  import pidis_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               kind_i,
  input  wire logic [CHAN_W-1:0]  channel_i,
  input  wire logic signed [31:0] target_i,
  input  wire logic signed [31:0] measured_i,
  input  wire logic signed [15:0] gain_p_i,
  input  wire logic signed [15:0] gain_i_i,
  input  wire logic signed [15:0] gain_d_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [CHAN_W-1:0]       out_channel_o,
  output logic signed [31:0]      drive_o,
  output logic signed [31:0]      error_now_o,
  output logic signed [31:0]      integral_now_o,
  output logic                    separated_o
);

  localparam int QW = $bits(qitem_t);

  logic [THR_W-1:0] threshold_q;
  gain_adj_t        adj_q;
  logic             q_full, q_push, q_valid, q_pop;
  qitem_t           push_item, pop_item;
  logic [QW-1:0]    pop_bits;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THR_W'(983040);
      adj_q.kp_red <= ADJ_W'(179);
      adj_q.kd_adj <= ADJ_W'(128);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_THRESHOLD: threshold_q  <= cfg_data_i[THR_W-1:0];
        REG_KP_RED:    adj_q.kp_red <= cfg_data_i[ADJ_W-1:0];
        REG_KD_ADJ:    adj_q.kd_adj <= cfg_data_i[ADJ_W-1:0];
        default: ;
      endcase
    end
  end

  pidis_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .channel_i   (channel_i),
    .target_i    (target_i),
    .measured_i  (measured_i),
    .gain_p_i    (gain_p_i),
    .gain_i_i    (gain_i_i),
    .gain_d_i    (gain_d_i),
    .threshold_i (threshold_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  pidis_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (pop_bits)
  );

  assign pop_item = qitem_t'(pop_bits);

  pidis_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_item_i       (pop_item),
    .adj_i          (adj_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_channel_o  (out_channel_o),
    .drive_o        (drive_o),
    .error_now_o    (error_now_o),
    .integral_now_o (integral_now_o),
    .separated_o    (separated_o)
  );

endmodule

`default_nettype wire

[verif/pid_integral_separation_core_test.sv]
// Self-checking testbench for the multi-channel PID core with integral separation.
`timescale 1ns / 100ps

module pid_integral_separation_core_test;
  import pidis_pkg::*;

  localparam int CHANNELS = CHANNELS_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES = 8;
  localparam int REQUESTS_PER_PHASE = 142;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam longint MIN32 = -64'sd2147483648;
  localparam longint MAX32 = 64'sd2147483647;

  typedef struct {
    logic [CHAN_W-1:0]  channel;
    logic signed [31:0] drive;
    logic signed [31:0] error;
    logic signed [31:0] integral;
    logic               separated;
  } pid_result_t;

  // Tracks per-channel controller state and the queue of drive values still owed.
  class drive_scoreboard;
    pid_result_t        expected_q[$];
    logic signed [15:0] kp_base[CHANNELS];
    logic signed [15:0] ki_base[CHANNELS];
    logic signed [15:0] kd_base[CHANNELS];
    logic signed [31:0] last_err[CHANNELS];
    logic signed [31:0] err_sum[CHANNELS];
    logic [THR_W-1:0]   threshold;
    logic [ADJ_W-1:0]   kp_cut;
    logic [ADJ_W-1:0]   kd_step;
    int                 failures;

    function new();
      foreach (kp_base[c]) begin
        kp_base[c] = '0;
        ki_base[c] = '0;
        kd_base[c] = '0;
        last_err[c] = '0;
        err_sum[c] = '0;
      end
      threshold = 31'd983040;
      kp_cut = 15'd179;
      kd_step = 15'd128;
      failures = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_THRESHOLD: threshold = data[THR_W-1:0];
        REG_KP_RED: kp_cut = data[ADJ_W-1:0];
        REG_KD_ADJ: kd_step = data[ADJ_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(kind_e k, logic [CHAN_W-1:0] ch, logic signed [31:0] tgt,
                               logic signed [31:0] meas, logic signed [15:0] gp,
                               logic signed [15:0] gi, logic signed [15:0] gd);
      longint      e;
      longint      mag;
      longint      kp;
      longint      ki;
      longint      kd;
      longint      total;
      logic        in_band;
      pid_result_t r;
      if (k == KIND_CONFIG) begin
        kp_base[ch] = gp;
        ki_base[ch] = gi;
        kd_base[ch] = gd;
        last_err[ch] = '0;
        err_sum[ch] = '0;
        return;
      end
      e = clamp(longint'(tgt) - longint'(meas), MIN32, MAX32);
      // The most negative error has magnitude 2^31, which no threshold can exceed.
      mag = (e < 0) ? -e : e;
      in_band = (mag < longint'(threshold));
      if (in_band) begin
        err_sum[ch] = 32'(clamp(longint'(err_sum[ch]) + e, MIN32, MAX32));
        kp = clamp(longint'(kp_base[ch]) - longint'(kp_cut), -32768, 32767);
        kd = clamp(longint'(kd_base[ch]) - longint'(kd_step), -32768, 32767);
        ki = longint'(ki_base[ch]);
      end else begin
        err_sum[ch] = '0;
        kp = longint'(kp_base[ch]);
        kd = clamp(longint'(kd_base[ch]) + longint'(kd_step), -32768, 32767);
        ki = 0;
      end
      // The derivative difference is kept at full width, not saturated.
      total = kp * e + ki * longint'(err_sum[ch]) + kd * (e - longint'(last_err[ch]));
      last_err[ch] = 32'(e);
      r.channel = ch;
      r.drive = 32'(clamp(total >>> 8, MIN32, MAX32));
      r.error = 32'(e);
      r.integral = err_sum[ch];
      r.separated = !in_band;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [CHAN_W-1:0] ch, logic signed [31:0] drv,
                               logic signed [31:0] err, logic signed [31:0] integ,
                               logic sep);
      pid_result_t want;
      if (expected_q.size() == 0) begin
        $error("result on channel %0d with no step request outstanding", ch);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (ch !== want.channel) begin
        $error("out_channel: expected %0d, got %0d", want.channel, ch);
        failures++;
      end
      if (drv !== want.drive) begin
        $error("drive: expected %0d, got %0d", want.drive, drv);
        failures++;
      end
      if (err !== want.error) begin
        $error("error_now: expected %0d, got %0d", want.error, err);
        failures++;
      end
      if (integ !== want.integral) begin
        $error("integral_now: expected %0d, got %0d", want.integral, integ);
        failures++;
      end
      if (sep !== want.separated) begin
        $error("separated: expected %0d, got %0d", want.separated, sep);
        failures++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               kind_i = 1'b0;
  logic [CHAN_W-1:0]  channel_i = '0;
  logic signed [31:0] target_i = '0;
  logic signed [31:0] measured_i = '0;
  logic signed [15:0] gain_p_i = '0;
  logic signed [15:0] gain_i_i = '0;
  logic signed [15:0] gain_d_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CHAN_W-1:0]  out_channel_o;
  logic signed [31:0] drive_o;
  logic signed [31:0] error_now_o;
  logic signed [31:0] integral_now_o;
  logic               separated_o;

  drive_scoreboard sb = new();
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;
  int idle_cycles = 0;

  pid_integral_separation_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .kind_i(kind_i),
    .channel_i(channel_i),
    .target_i(target_i),
    .measured_i(measured_i),
    .gain_p_i(gain_p_i),
    .gain_i_i(gain_i_i),
    .gain_d_i(gain_d_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_channel_o(out_channel_o),
    .drive_o(drive_o),
    .error_now_o(error_now_o),
    .integral_now_o(integral_now_o),
    .separated_o(separated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Everything sampled here holds its pre-edge value, so process order does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(kind_e'(kind_i), channel_i, target_i, measured_i,
                        gain_p_i, gain_i_i, gain_d_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_channel_o, drive_o, error_now_o, integral_now_o, separated_o);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_register(cfg_index_i, cfg_data_i);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("pid_integral_separation_core: mismatch");
      $finish;
    end
  end

  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_request(kind_e k, logic [CHAN_W-1:0] ch, logic [31:0] tgt,
                              logic [31:0] meas, logic [15:0] gp, logic [15:0] gi,
                              logic [15:0] gd);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    channel_i <= ch;
    target_i <= tgt;
    measured_i <= meas;
    gain_p_i <= gp;
    gain_i_i <= gi;
    gain_d_i <= gd;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Configure requests give no result, so allow the pipeline to empty after the last one.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  task automatic random_request();
    kind_e       k;
    logic [1:0]  ch;
    logic [31:0] tgt;
    logic [31:0] meas;
    longint      delta;
    int          pick;
    k = ($urandom_range(0, 9) == 0) ? KIND_CONFIG : KIND_STEP;
    ch = 2'($urandom_range(0, CHANNELS - 1));
    meas = $urandom;
    tgt = $urandom;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      // Errors spread across the band so the integral gets to accumulate.
      delta = longint'($urandom_range(0, {sb.threshold, 1'b0})) - longint'(sb.threshold);
      tgt = 32'(longint'($signed(meas)) + delta);
    end else if (pick < 14) begin
      delta = longint'(sb.threshold) + longint'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1)) delta = -delta;
      tgt = 32'(longint'($signed(meas)) + delta);
    end else if (pick >= 17) begin
      tgt = edge_value();
      meas = edge_value();
    end
    send_request(k, ch, tgt, meas, pick_gain(), pick_gain(), pick_gain());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Gains at both extremes plus a couple of ordinary sets, under reset settings.
    send_request(KIND_CONFIG, 2'd0, '0, '0, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(KIND_CONFIG, 2'd1, '0, '0, 16'h8000, 16'h8000, 16'h8000);
    send_request(KIND_CONFIG, 2'd2, '0, '0, 16'h0100, 16'h0080, 16'h0040);
    send_request(KIND_CONFIG, 2'd3, '0, '0, 16'hffff, 16'h0000, 16'h0001);
    send_request(KIND_STEP, 2'd2, 32'h0, 32'h0, '0, '0, '0);
    send_request(KIND_STEP, 2'd2, 32'h0001_0000, 32'h0, '0, '0, '0);
    // Error magnitude equal to the threshold falls outside the band.
    send_request(KIND_STEP, 2'd2, 32'd983040, 32'h0, '0, '0, '0);
    send_request(KIND_STEP, 2'd2, 32'h0, 32'd983039, '0, '0, '0);
    send_request(KIND_STEP, 2'd0, 32'h7fff_ffff, 32'h8000_0000, '0, '0, '0);
    send_request(KIND_STEP, 2'd0, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0);
    send_request(KIND_STEP, 2'd1, 32'h8000_0000, 32'h0, '0, '0, '0);
    send_request(KIND_STEP, 2'd1, 32'd5, 32'd3, '0, '0, '0);
    send_request(KIND_STEP, 2'd0, 32'h100, 32'h0, '0, '0, '0);
    // A swing from the most negative to the most positive error stresses the derivative.
    send_request(KIND_STEP, 2'd3, 32'h8000_0000, 32'h0, '0, '0, '0);
    send_request(KIND_STEP, 2'd3, 32'h7fff_ffff, 32'h0, '0, '0, '0);
    send_request(KIND_CONFIG, 2'd2, '0, '0, 16'h1234, 16'hfe00, 16'h0080);
    send_request(KIND_STEP, 2'd2, 32'h0000_8000, 32'h0, '0, '0, '0);

    // Widest band and largest adjustments; the integral saturates both ways.
    drain_pipeline();
    write_register(REG_THRESHOLD, 32'hffff_ffff);
    write_register(REG_KP_RED, 32'h0000_7fff);
    write_register(REG_KD_ADJ, 32'h0000_7fff);
    write_register(REG_SPARE, 32'h0000_0000);
    send_request(KIND_STEP, 2'd0, 32'h7fff_fffe, 32'h0, '0, '0, '0);
    send_request(KIND_STEP, 2'd0, 32'h7fff_fffe, 32'h0, '0, '0, '0);
    send_request(KIND_STEP, 2'd1, 32'h8000_0002, 32'h0, '0, '0, '0);
    send_request(KIND_STEP, 2'd1, 32'h8000_0002, 32'h0, '0, '0, '0);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      case (phase)
        0: begin
          write_register(REG_THRESHOLD, 32'd983040);
          write_register(REG_KP_RED, 32'd179);
          write_register(REG_KD_ADJ, 32'd128);
        end
        1: begin
          // Only the top bit set: the band collapses to nothing.
          write_register(REG_THRESHOLD, 32'h8000_0000);
          write_register(REG_KP_RED, 32'h0);
          write_register(REG_KD_ADJ, 32'hffff_8000);
        end
        2: begin
          write_register(REG_THRESHOLD, 32'h7fff_ffff);
          write_register(REG_KP_RED, 32'hffff_ffff);
          write_register(REG_KD_ADJ, 32'hffff_ffff);
        end
        default: begin
          write_register(REG_SPARE, $urandom);
          write_register(REG_THRESHOLD,
                         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 24));
          write_register(REG_KP_RED, $urandom);
          write_register(REG_KD_ADJ, $urandom);
        end
      endcase
      in_steady = (phase % 3 == 1);
      out_steady = (phase % 4 == 2);
      repeat (REQUESTS_PER_PHASE) random_request();
    end

    drain_pipeline();
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("pid_integral_separation_core: match");
    end else begin
      $display("pid_integral_separation_core: mismatch");
    end
    $finish;
  end

endmodule
